>>> src/mprj_pkg.sv
// Shared constants, codes and types for the pose residual and Jacobian core.
`timescale 1ns / 1ps

package mprj_pkg;

	// Default lane width and the fixed widths of the fields.
	localparam int LANE_BITS_DEF = 21;
	localparam int FIELD_W = 63;
	localparam int RES_W = 32;
	localparam int KIND_W = 2;

	// Configuration register file.
	localparam int NUM_CFG = 8;
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_ROT_I_ROW0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROT_I_ROW1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROT_I_ROW2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TRANS_I = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ROT_J_ROW0 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_ROT_J_ROW1 = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_ROT_J_ROW2 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_TRANS_J = 3'd7;

	// Correspondence kinds.
	localparam logic [KIND_W-1:0] KIND_PLANE_POINT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_POINT_PLANE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_POINT_POINT = 2'd2;
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	// Index of the final row of a point-point correspondence.
	localparam logic [1:0] LAST_PP_ROW = 2'd2;

	// Control that travels with every row through the pipeline.
	typedef struct packed {
		logic       swap;
		logic       pp;
		logic       last;
		logic [1:0] row;
	} row_ctl_t;

endpackage

>>> src/mprj_row_issue.sv
// Input stage: holds one correspondence and issues its rows one per cycle while the pipeline accepts them.
`timescale 1ns / 1ps

module mprj_row_issue (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [mprj_pkg::KIND_W-1:0]    kind,
	input  logic [mprj_pkg::FIELD_W-1:0]   point_i,
	input  logic [mprj_pkg::FIELD_W-1:0]   point_j,
	input  logic [mprj_pkg::FIELD_W-1:0]   normal,
	output logic                           iss_valid,
	input  logic                           iss_ready,
	output mprj_pkg::row_ctl_t             iss_ctl,
	output logic [mprj_pkg::FIELD_W-1:0]   iss_pi,
	output logic [mprj_pkg::FIELD_W-1:0]   iss_pj,
	output logic [mprj_pkg::FIELD_W-1:0]   iss_n
);

	logic                         hold_q;
	logic [1:0]                   row_q;
	logic [mprj_pkg::KIND_W-1:0]  kind_q;
	logic [mprj_pkg::FIELD_W-1:0] pi_q;
	logic [mprj_pkg::FIELD_W-1:0] pj_q;
	logic [mprj_pkg::FIELD_W-1:0] n_q;
	logic                         is_pp;
	logic                         is_last;
	logic                         done;
	logic                         take;

	// The held item leaves once its last row is taken; a new beat may enter then.
	assign is_pp = (kind_q == mprj_pkg::KIND_POINT_POINT);
	assign is_last = !is_pp || (row_q == mprj_pkg::LAST_PP_ROW);
	assign done = hold_q && iss_ready && is_last;
	assign in_stall = hold_q && !done;
	assign take = in_valid && !in_stall;

	// Hold flag and row counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
			row_q <= 2'd0;
		end else if (take) begin
			hold_q <= (kind != mprj_pkg::KIND_UNUSED);
			row_q <= 2'd0;
		end else if (done) begin
			hold_q <= 1'b0;
		end else if (hold_q && iss_ready) begin
			row_q <= row_q + 2'd1;
		end
	end

	// Item payload.
	always_ff @(posedge clk) begin
		if (take) begin
			kind_q <= kind;
			pi_q <= point_i;
			pj_q <= point_j;
			n_q <= normal;
		end
	end

	assign iss_valid = hold_q;
	assign iss_ctl.swap = (kind_q == mprj_pkg::KIND_POINT_PLANE);
	assign iss_ctl.pp = is_pp;
	assign iss_ctl.last = is_last;
	assign iss_ctl.row = row_q;
	assign iss_pi = pi_q;
	assign iss_pj = pj_q;
	assign iss_n = n_q;

endmodule

>>> src/mprj_datapath.sv
// Four-stage arithmetic pipeline: transforms, residual, back-rotations and crosses.
`timescale 1ns / 1ps

module mprj_datapath #(
	parameter int LANE_BITS = mprj_pkg::LANE_BITS_DEF,
	localparam int L = LANE_BITS,
	localparam int F = LANE_BITS - 2,
	localparam int QW = 2 * LANE_BITS + 2,
	localparam int WW = QW - (LANE_BITS - 2),
	localparam int VRW = 2 * LANE_BITS + 3,
	localparam int VW = VRW - (LANE_BITS - 2),
	localparam int AW = 2 * LANE_BITS + 10,
	localparam int RSW = AW - (LANE_BITS - 2),
	localparam int ANTW = 2 * LANE_BITS + 5,
	localparam int ANW = ANTW - (LANE_BITS - 2),
	localparam int AVTW = 2 * LANE_BITS + 6,
	localparam int AVW = AVTW - (LANE_BITS - 2),
	localparam int CW = 2 * LANE_BITS + 9,
	localparam int CBW = 2 * LANE_BITS + 7
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [mprj_pkg::FIELD_W-1:0]      cfg [mprj_pkg::NUM_CFG],
	input  logic                              up_valid,
	output logic                              up_ready,
	input  mprj_pkg::row_ctl_t                up_ctl,
	input  logic [mprj_pkg::FIELD_W-1:0]      up_pi,
	input  logic [mprj_pkg::FIELD_W-1:0]      up_pj,
	input  logic [mprj_pkg::FIELD_W-1:0]      up_n,
	output logic                              dn_valid,
	input  logic                              dn_ready,
	output mprj_pkg::row_ctl_t                dn_ctl,
	output logic signed [RSW-1:0]             dn_res,
	output logic signed [CW-1:0]              dn_c [3],
	output logic signed [CBW-1:0]             dn_cb [3],
	output logic signed [ANW-1:0]             dn_an [3],
	output logic signed [ANW-1:0]             dn_bn [3]
);

	localparam logic signed [F:0] HALF = {1'b0, 1'b1, {(F-1){1'b0}}};

	function automatic logic signed [L-1:0] lane(input logic [mprj_pkg::FIELD_W-1:0] x,
		input int k);
		return $signed(x[k*L +: L]);
	endfunction

	// Pose registers split into lanes.
	logic signed [L-1:0] ri [3][3];
	logic signed [L-1:0] rj [3][3];
	logic signed [L-1:0] ti [3];
	logic signed [L-1:0] tj [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			ri[0][k] = lane(cfg[mprj_pkg::CFG_ROT_I_ROW0], k);
			ri[1][k] = lane(cfg[mprj_pkg::CFG_ROT_I_ROW1], k);
			ri[2][k] = lane(cfg[mprj_pkg::CFG_ROT_I_ROW2], k);
			rj[0][k] = lane(cfg[mprj_pkg::CFG_ROT_J_ROW0], k);
			rj[1][k] = lane(cfg[mprj_pkg::CFG_ROT_J_ROW1], k);
			rj[2][k] = lane(cfg[mprj_pkg::CFG_ROT_J_ROW2], k);
			ti[k] = lane(cfg[mprj_pkg::CFG_TRANS_I], k);
			tj[k] = lane(cfg[mprj_pkg::CFG_TRANS_J], k);
		end
	end

	// Stage enables: a stage loads when it is empty or its successor moves.
	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	assign en4 = !v_s4 || dn_ready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign up_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= up_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// Stage 1: order the poses and points, then transform both points and the normal.
	logic signed [L-1:0]  ra0 [3][3];
	logic signed [L-1:0]  rb0 [3][3];
	logic signed [L-1:0]  pa0 [3];
	logic signed [L-1:0]  pb0 [3];
	logic signed [L-1:0]  na0 [3];
	logic signed [QW-1:0] qa0 [3];
	logic signed [QW-1:0] qb0 [3];
	logic signed [QW-1:0] wt0 [3];
	logic signed [WW-1:0] w0 [3];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				ra0[r][c] = up_ctl.swap ? rj[r][c] : ri[r][c];
				rb0[r][c] = up_ctl.swap ? ri[r][c] : rj[r][c];
			end
			pa0[r] = lane(up_ctl.swap ? up_pj : up_pi, r);
			pb0[r] = lane(up_ctl.swap ? up_pi : up_pj, r);
			na0[r] = lane(up_n, r);
		end
		for (int r = 0; r < 3; r++) begin
			qa0[r] = ra0[r][0] * pa0[0] + ra0[r][1] * pa0[1] + ra0[r][2] * pa0[2];
			qb0[r] = rb0[r][0] * pb0[0] + rb0[r][1] * pb0[1] + rb0[r][2] * pb0[2];
			wt0[r] = ra0[r][0] * na0[0] + ra0[r][1] * na0[1] + ra0[r][2] * na0[2] + HALF;
			w0[r] = wt0[r][QW-1:F];
		end
	end

	mprj_pkg::row_ctl_t   ctl_s1;
	logic signed [L-1:0]  pa_s1 [3];
	logic signed [L-1:0]  pb_s1 [3];
	logic signed [L-1:0]  na_s1 [3];
	logic signed [QW-1:0] qa_s1 [3];
	logic signed [QW-1:0] qb_s1 [3];
	logic signed [WW-1:0] w_s1 [3];

	always_ff @(posedge clk) begin
		if (en1) begin
			ctl_s1 <= up_ctl;
			pa_s1 <= pa0;
			pb_s1 <= pb0;
			na_s1 <= na0;
			qa_s1 <= qa0;
			qb_s1 <= qb0;
			w_s1 <= w0;
		end
	end

	// Stage 2: difference vector between the two transformed points.
	logic signed [VRW-1:0] vt1 [3];
	logic signed [VW-1:0]  v1 [3];
	logic signed [L-1:0]   ta1 [3];
	logic signed [L-1:0]   tb1 [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			ta1[k] = ctl_s1.swap ? tj[k] : ti[k];
			tb1[k] = ctl_s1.swap ? ti[k] : tj[k];
			vt1[k] = qb_s1[k] - qa_s1[k] + ((tb1[k] - ta1[k]) <<< F) + HALF;
			v1[k] = vt1[k][VRW-1:F];
		end
	end

	mprj_pkg::row_ctl_t   ctl_s2;
	logic signed [L-1:0]  pa_s2 [3];
	logic signed [L-1:0]  pb_s2 [3];
	logic signed [L-1:0]  na_s2 [3];
	logic signed [WW-1:0] w_s2 [3];
	logic signed [VW-1:0] v_s2_vec [3];

	always_ff @(posedge clk) begin
		if (en2) begin
			ctl_s2 <= ctl_s1;
			pa_s2 <= pa_s1;
			pb_s2 <= pb_s1;
			na_s2 <= na_s1;
			w_s2 <= w_s1;
			v_s2_vec <= v1;
		end
	end

	// Stage 3: residual sum and the three back-rotated vectors.
	// A point-point row uses its rotation rows directly and takes one lane of v.
	logic signed [L-1:0]    ra2 [3][3];
	logic signed [L-1:0]    rb2 [3][3];
	logic signed [AW-1:0]   acc2;
	logic signed [ANTW-1:0] ant2 [3];
	logic signed [ANTW-1:0] bnt2 [3];
	logic signed [AVTW-1:0] avt2 [3];
	logic signed [ANW-1:0]  an2 [3];
	logic signed [ANW-1:0]  bn2 [3];
	logic signed [AVW-1:0]  av2 [3];
	logic signed [VW-1:0]   resv2;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				ra2[r][c] = ctl_s2.swap ? rj[r][c] : ri[r][c];
				rb2[r][c] = ctl_s2.swap ? ri[r][c] : rj[r][c];
			end
		end
		acc2 = w_s2[0] * v_s2_vec[0] + w_s2[1] * v_s2_vec[1] + w_s2[2] * v_s2_vec[2];
		resv2 = v_s2_vec[0];
		for (int k = 0; k < 3; k++) begin
			ant2[k] = ra2[0][k] * w_s2[0] + ra2[1][k] * w_s2[1] + ra2[2][k] * w_s2[2]
				+ HALF;
			bnt2[k] = rb2[0][k] * w_s2[0] + rb2[1][k] * w_s2[1] + rb2[2][k] * w_s2[2]
				+ HALF;
			avt2[k] = ra2[0][k] * v_s2_vec[0] + ra2[1][k] * v_s2_vec[1]
				+ ra2[2][k] * v_s2_vec[2] + HALF;
			an2[k] = ant2[k][ANTW-1:F];
			bn2[k] = bnt2[k][ANTW-1:F];
			av2[k] = avt2[k][AVTW-1:F];
		end
		if (ctl_s2.pp) begin
			for (int r = 0; r < 3; r++) begin
				if (ctl_s2.row == 2'(r)) begin
					resv2 = v_s2_vec[r];
					for (int k = 0; k < 3; k++) begin
						an2[k] = ANW'(ra2[r][k]);
						bn2[k] = ANW'(rb2[r][k]);
					end
				end
			end
			for (int k = 0; k < 3; k++) begin
				av2[k] = '0;
			end
		end
	end

	mprj_pkg::row_ctl_t    ctl_s3;
	logic signed [L-1:0]   pa_s3 [3];
	logic signed [L-1:0]   pb_s3 [3];
	logic signed [L-1:0]   na_s3 [3];
	logic signed [AW-1:0]  acc_s3;
	logic signed [VW-1:0]  resv_s3;
	logic signed [ANW-1:0] an_s3 [3];
	logic signed [ANW-1:0] bn_s3 [3];
	logic signed [AVW-1:0] av_s3 [3];

	always_ff @(posedge clk) begin
		if (en3) begin
			ctl_s3 <= ctl_s2;
			pa_s3 <= pa_s2;
			pb_s3 <= pb_s2;
			na_s3 <= na_s2;
			acc_s3 <= acc2;
			resv_s3 <= resv2;
			an_s3 <= an2;
			bn_s3 <= bn2;
			av_s3 <= av2;
		end
	end

	// Stage 4: rounded residual and the raw cross products.
	logic signed [AW-1:0]  acct3;
	logic signed [RSW-1:0] res3;
	logic signed [CW-1:0]  c3 [3];
	logic signed [CBW-1:0] cb3 [3];

	always_comb begin
		acct3 = acc_s3 + HALF;
		res3 = ctl_s3.pp ? RSW'(resv_s3) : acct3[AW-1:F];
		c3[0] = an_s3[1] * pa_s3[2] - an_s3[2] * pa_s3[1]
			- (av_s3[1] * na_s3[2] - av_s3[2] * na_s3[1]);
		c3[1] = an_s3[2] * pa_s3[0] - an_s3[0] * pa_s3[2]
			- (av_s3[2] * na_s3[0] - av_s3[0] * na_s3[2]);
		c3[2] = an_s3[0] * pa_s3[1] - an_s3[1] * pa_s3[0]
			- (av_s3[0] * na_s3[1] - av_s3[1] * na_s3[0]);
		cb3[0] = bn_s3[2] * pb_s3[1] - bn_s3[1] * pb_s3[2];
		cb3[1] = bn_s3[0] * pb_s3[2] - bn_s3[2] * pb_s3[0];
		cb3[2] = bn_s3[1] * pb_s3[0] - bn_s3[0] * pb_s3[1];
	end

	mprj_pkg::row_ctl_t    ctl_s4;
	logic signed [RSW-1:0] res_s4;
	logic signed [CW-1:0]  c_s4 [3];
	logic signed [CBW-1:0] cb_s4 [3];
	logic signed [ANW-1:0] an_s4 [3];
	logic signed [ANW-1:0] bn_s4 [3];

	always_ff @(posedge clk) begin
		if (en4) begin
			ctl_s4 <= ctl_s3;
			res_s4 <= res3;
			c_s4 <= c3;
			cb_s4 <= cb3;
			an_s4 <= an_s3;
			bn_s4 <= bn_s3;
		end
	end

	assign dn_valid = v_s4;
	assign dn_ctl = ctl_s4;
	assign dn_res = res_s4;
	assign dn_c = c_s4;
	assign dn_cb = cb_s4;
	assign dn_an = an_s4;
	assign dn_bn = bn_s4;

`ifndef SYNTHESIS
	a_s4_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !dn_ready |=> v_s4 && $stable(res_s4) && $stable(ctl_s4))
		else $error("stage 4 beat changed while blocked");
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !en2 |=> v_s1 && $stable(ctl_s1))
		else $error("stage 1 beat changed while blocked");
	a_pp_noswap: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && ctl_s3.pp |-> !ctl_s3.swap)
		else $error("point-point row carries a pose swap");
	a_plane_last: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !ctl_s2.pp |-> ctl_s2.last)
		else $error("plane row not marked as last");
`endif

endmodule

>>> src/mprj_out_stage.sv
// Output register: final rounding, saturation, packing and Jacobian ordering.
`timescale 1ns / 1ps

module mprj_out_stage #(
	parameter int LANE_BITS = mprj_pkg::LANE_BITS_DEF,
	localparam int L = LANE_BITS,
	localparam int F = LANE_BITS - 2,
	localparam int RSW = 2 * LANE_BITS + 10 - (LANE_BITS - 2),
	localparam int ANW = 2 * LANE_BITS + 5 - (LANE_BITS - 2),
	localparam int CW = 2 * LANE_BITS + 9,
	localparam int CBW = 2 * LANE_BITS + 7,
	localparam int SW = LANE_BITS + 12
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 up_valid,
	output logic                                 up_ready,
	input  mprj_pkg::row_ctl_t                   up_ctl,
	input  logic signed [RSW-1:0]                up_res,
	input  logic signed [CW-1:0]                 up_c [3],
	input  logic signed [CBW-1:0]                up_cb [3],
	input  logic signed [ANW-1:0]                up_an [3],
	input  logic signed [ANW-1:0]                up_bn [3],
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [mprj_pkg::RES_W-1:0]    row_residual,
	output logic [mprj_pkg::FIELD_W-1:0]         h1_rotation,
	output logic [mprj_pkg::FIELD_W-1:0]         h1_translation,
	output logic [mprj_pkg::FIELD_W-1:0]         h2_rotation,
	output logic [mprj_pkg::FIELD_W-1:0]         h2_translation,
	output logic                                 last_row,
	output logic                                 saturated
);

	localparam logic signed [F:0] HALF = {1'b0, 1'b1, {(F-1){1'b0}}};
	localparam logic signed [SW-1:0] LANE_MAX = {{(SW-L+1){1'b0}}, {(L-1){1'b1}}};
	localparam logic signed [SW-1:0] LANE_MIN = {{(SW-L+1){1'b1}}, {(L-1){1'b0}}};
	localparam logic signed [63:0] RES_MAX = {{33{1'b0}}, {31{1'b1}}};
	localparam logic signed [63:0] RES_MIN = {{33{1'b1}}, {31{1'b0}}};

	// Clip to a signed lane; the top bit of the result flags a clip.
	function automatic logic [L:0] sat_lane(input logic signed [SW-1:0] x);
		if (x > LANE_MAX) begin
			return {1'b1, LANE_MAX[L-1:0]};
		end else if (x < LANE_MIN) begin
			return {1'b1, LANE_MIN[L-1:0]};
		end
		return {1'b0, x[L-1:0]};
	endfunction

	logic signed [CW-1:0]  ct [3];
	logic signed [CBW-1:0] cbt [3];
	logic [L:0]            ar [3];
	logic [L:0]            at [3];
	logic [L:0]            br [3];
	logic [L:0]            bt [3];
	logic signed [63:0]    res_ext;
	logic signed [mprj_pkg::RES_W-1:0] res_sat;
	logic                  res_clip;
	logic [mprj_pkg::FIELD_W-1:0] ar_f, at_f, br_f, bt_f;
	logic                  any_clip;
	logic                  en;

	// Round the cross products, clip every lane and pack.
	always_comb begin
		any_clip = 1'b0;
		ar_f = '0;
		at_f = '0;
		br_f = '0;
		bt_f = '0;
		for (int k = 0; k < 3; k++) begin
			ct[k] = up_c[k] + HALF;
			cbt[k] = up_cb[k] + HALF;
			ar[k] = sat_lane(SW'($signed(ct[k][CW-1:F])));
			br[k] = sat_lane(SW'($signed(cbt[k][CBW-1:F])));
			at[k] = sat_lane(-SW'(up_an[k]));
			bt[k] = sat_lane(SW'(up_bn[k]));
			any_clip = any_clip | ar[k][L] | br[k][L] | at[k][L] | bt[k][L];
			ar_f[k*L +: L] = ar[k][L-1:0];
			at_f[k*L +: L] = at[k][L-1:0];
			br_f[k*L +: L] = br[k][L-1:0];
			bt_f[k*L +: L] = bt[k][L-1:0];
		end
		res_ext = 64'(up_res);
		res_clip = 1'b1;
		if (res_ext > RES_MAX) begin
			res_sat = RES_MAX[mprj_pkg::RES_W-1:0];
		end else if (res_ext < RES_MIN) begin
			res_sat = RES_MIN[mprj_pkg::RES_W-1:0];
		end else begin
			res_sat = res_ext[mprj_pkg::RES_W-1:0];
			res_clip = 1'b0;
		end
	end

	assign en = !out_valid || !out_stall;
	assign up_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= up_valid;
		end
	end

	// A point-plane row was computed with the poses swapped; put H1 and H2 back.
	always_ff @(posedge clk) begin
		if (en) begin
			row_residual <= res_sat;
			h1_rotation <= up_ctl.swap ? br_f : ar_f;
			h1_translation <= up_ctl.swap ? bt_f : at_f;
			h2_rotation <= up_ctl.swap ? ar_f : br_f;
			h2_translation <= up_ctl.swap ? at_f : bt_f;
			last_row <= up_ctl.last;
			saturated <= any_clip | res_clip;
		end
	end

endmodule

>>> src/mixed_pose_residual_jacobian_core.sv
// Top level of the pose residual and Jacobian core with its register file.
`timescale 1ns / 1ps

// Residual and Jacobian rows for ICP correspondences between two poses.
// Poses i and j (rotation rows, translations) are written through the
// register port (cfg_write, cfg_index, cfg_data); the user must write them
// only while the core is idle, which the block itself does not enforce.
// Input beats (in_valid / in_stall) carry one correspondence each; output
// beats (out_valid / out_stall) carry one Jacobian row each.
// Plane-point and point-plane items give one row, point-point items give
// three rows with last_row set on the third, and an unused kind gives none.
// The input stage issues one row per cycle into a five-register pipeline,
// unless it stalls, and takes a new item as the held item's last row is
// issued. A row passes the issue register, stages 1 to 4 and the output
// register. Reset loads identity rotations and zero translations and empties
// the pipeline. When the receiver stalls, each stage holds its beat and the
// pipeline fills up with in_stall raised; nothing is lost or repeated.
module mixed_pose_residual_jacobian_core #(
	parameter int LANE_BITS = mprj_pkg::LANE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [mprj_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mprj_pkg::FIELD_W-1:0]         cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [mprj_pkg::KIND_W-1:0]          kind,
	input  logic [mprj_pkg::FIELD_W-1:0]         point_i,
	input  logic [mprj_pkg::FIELD_W-1:0]         point_j,
	input  logic [mprj_pkg::FIELD_W-1:0]         normal,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [mprj_pkg::RES_W-1:0]    row_residual,
	output logic [mprj_pkg::FIELD_W-1:0]         h1_rotation,
	output logic [mprj_pkg::FIELD_W-1:0]         h1_translation,
	output logic [mprj_pkg::FIELD_W-1:0]         h2_rotation,
	output logic [mprj_pkg::FIELD_W-1:0]         h2_translation,
	output logic                                 last_row,
	output logic                                 saturated
);

	localparam int L = LANE_BITS;
	localparam int F = LANE_BITS - 2;
	localparam int FW = mprj_pkg::FIELD_W;
	localparam int RSW = 2 * LANE_BITS + 10 - (LANE_BITS - 2);
	localparam int ANW = 2 * LANE_BITS + 5 - (LANE_BITS - 2);
	localparam int CW = 2 * LANE_BITS + 9;
	localparam int CBW = 2 * LANE_BITS + 7;
	localparam logic [FW-1:0] ROT_ROW0 = FW'(1) << F;
	localparam logic [FW-1:0] ROT_ROW1 = ROT_ROW0 << L;
	localparam logic [FW-1:0] ROT_ROW2 = ROT_ROW0 << (2 * L);

	// Pose register file.
	logic [FW-1:0] cfg_q [mprj_pkg::NUM_CFG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[mprj_pkg::CFG_ROT_I_ROW0] <= ROT_ROW0;
			cfg_q[mprj_pkg::CFG_ROT_I_ROW1] <= ROT_ROW1;
			cfg_q[mprj_pkg::CFG_ROT_I_ROW2] <= ROT_ROW2;
			cfg_q[mprj_pkg::CFG_TRANS_I] <= '0;
			cfg_q[mprj_pkg::CFG_ROT_J_ROW0] <= ROT_ROW0;
			cfg_q[mprj_pkg::CFG_ROT_J_ROW1] <= ROT_ROW1;
			cfg_q[mprj_pkg::CFG_ROT_J_ROW2] <= ROT_ROW2;
			cfg_q[mprj_pkg::CFG_TRANS_J] <= '0;
		end else if (cfg_write) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	// Row issue.
	logic               iss_valid, iss_ready;
	mprj_pkg::row_ctl_t iss_ctl;
	logic [FW-1:0]      iss_pi, iss_pj, iss_n;

	mprj_row_issue u_issue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.point_i   (point_i),
		.point_j   (point_j),
		.normal    (normal),
		.iss_valid (iss_valid),
		.iss_ready (iss_ready),
		.iss_ctl   (iss_ctl),
		.iss_pi    (iss_pi),
		.iss_pj    (iss_pj),
		.iss_n     (iss_n)
	);

	// Arithmetic pipeline.
	logic                  dp_valid, dp_ready;
	mprj_pkg::row_ctl_t    dp_ctl;
	logic signed [RSW-1:0] dp_res;
	logic signed [CW-1:0]  dp_c [3];
	logic signed [CBW-1:0] dp_cb [3];
	logic signed [ANW-1:0] dp_an [3];
	logic signed [ANW-1:0] dp_bn [3];

	mprj_datapath #(
		.LANE_BITS (LANE_BITS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.up_valid (iss_valid),
		.up_ready (iss_ready),
		.up_ctl   (iss_ctl),
		.up_pi    (iss_pi),
		.up_pj    (iss_pj),
		.up_n     (iss_n),
		.dn_valid (dp_valid),
		.dn_ready (dp_ready),
		.dn_ctl   (dp_ctl),
		.dn_res   (dp_res),
		.dn_c     (dp_c),
		.dn_cb    (dp_cb),
		.dn_an    (dp_an),
		.dn_bn    (dp_bn)
	);

	// Output register.
	mprj_out_stage #(
		.LANE_BITS (LANE_BITS)
	) u_out (
		.clk            (clk),
		.arst_n         (arst_n),
		.up_valid       (dp_valid),
		.up_ready       (dp_ready),
		.up_ctl         (dp_ctl),
		.up_res         (dp_res),
		.up_c           (dp_c),
		.up_cb          (dp_cb),
		.up_an          (dp_an),
		.up_bn          (dp_bn),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.row_residual   (row_residual),
		.h1_rotation    (h1_rotation),
		.h1_translation (h1_translation),
		.h2_rotation    (h2_rotation),
		.h2_translation (h2_translation),
		.last_row       (last_row),
		.saturated      (saturated)
	);

endmodule
